// ===== src/slbt_pkg.sv =====
// Shared constants for the scan line blanking timer.
// Register indexes, reset values and field widths; no dependencies.
package slbt_pkg;

    localparam int COUNTER_BITS_DEF = 24;
    localparam int OFFSET_W         = 24;
    localparam int PERIOD_OUT_W     = 24;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 32;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 32;
    localparam int NUM_CH           = 2;

    localparam logic [OFFSET_W-1:0] PRE_RESET  = OFFSET_W'(1200);
    localparam logic [OFFSET_W-1:0] POST_RESET = OFFSET_W'(20400);
    localparam int                  PERIOD_RESET = 42;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRE_A  = 8'd0,
        REG_POST_A = 8'd1,
        REG_PRE_B  = 8'd2,
        REG_POST_B = 8'd3
    } cfg_index_t;

endpackage

// ===== src/scan_line_blanking_timer_unit.sv =====
// Scan line blanking timer: line period measurement and two blanking windows.
// Depends on slbt_pkg for register indexes, reset values and widths.
//
// A tick taken on the input passes the input register, then the result register.
// Throughput: one tick per cycle while the result stream is not stalled.
// aresetn (synchronous, active low) clears the counter, edge time, channel
// references and blanking, sets the period to 42 and offsets to 1200/20400.
module scan_line_blanking_timer_unit #(
    parameter int COUNTER_BITS = slbt_pkg::COUNTER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tick stream: tdata [0] sync_edge, [7:1] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [slbt_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream: tdata [0] blank_a, [1] blank_b, [25:2] measured_period, [31:26] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [slbt_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slbt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [slbt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CB    = COUNTER_BITS;
    localparam int OW    = slbt_pkg::OFFSET_W;
    localparam int SUM_W = ((CB > OW) ? CB : OW) + 1;
    localparam int NCH   = slbt_pkg::NUM_CH;
    localparam int PW    = slbt_pkg::PERIOD_OUT_W;

    // offsets
    logic [OW-1:0] pre_reg  [NCH];
    logic [OW-1:0] post_reg [NCH];

    // input stage
    logic in_valid_reg;
    logic in_edge_reg;

    // timer state
    logic [CB-1:0] tick_reg;
    logic [CB-1:0] last_edge_reg, last_edge_next;
    logic [CB-1:0] period_reg, period_next;
    logic [CB-1:0] ref_reg  [NCH];
    logic [CB-1:0] ref_next [NCH];
    logic [NCH-1:0] blank_reg, blank_next;

    // result stage
    logic                        out_valid_reg;
    logic [NCH+PW-1:0]           out_data_reg;

    logic          advance;
    logic [SUM_W-1:0] period_ext, half_ext;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = slbt_pkg::OUT_TDATA_W'(out_data_reg);

    always_comb begin
        logic [CB-1:0]    elapsed;
        logic [SUM_W-1:0] el_ext, pre_ext, post_ext;
        logic             win_full, win_half;
        last_edge_next = last_edge_reg;
        period_next    = period_reg;
        if (in_edge_reg) begin
            period_next    = tick_reg - last_edge_reg;
            last_edge_next = tick_reg;
        end
        period_ext = SUM_W'(period_next);
        half_ext   = period_ext >> 1;
        for (int c = 0; c < NCH; c++) begin
            elapsed  = tick_reg - ref_reg[c];
            el_ext   = SUM_W'(elapsed);
            pre_ext  = SUM_W'(pre_reg[c]);
            post_ext = SUM_W'(post_reg[c]);
            win_full = (el_ext > period_ext + pre_ext) && (el_ext < period_ext + post_ext);
            win_half = (el_ext > half_ext + pre_ext) && (el_ext < half_ext + post_ext);
            blank_next[c] = win_full || win_half;
            ref_next[c]   = (!blank_next[c] && blank_reg[c]) ? last_edge_next : ref_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg[0]  <= slbt_pkg::PRE_RESET;
            post_reg[0] <= slbt_pkg::POST_RESET;
            pre_reg[1]  <= slbt_pkg::PRE_RESET;
            post_reg[1] <= slbt_pkg::POST_RESET;
        end else if (cfg_valid) begin
            case (slbt_pkg::cfg_index_t'(cfg_index))
                slbt_pkg::REG_PRE_A:  pre_reg[0]  <= cfg_data[OW-1:0];
                slbt_pkg::REG_POST_A: post_reg[0] <= cfg_data[OW-1:0];
                slbt_pkg::REG_PRE_B:  pre_reg[1]  <= cfg_data[OW-1:0];
                slbt_pkg::REG_POST_B: post_reg[1] <= cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_edge_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            last_edge_reg <= '0;
            period_reg    <= CB'(slbt_pkg::PERIOD_RESET);
            ref_reg[0]    <= '0;
            ref_reg[1]    <= '0;
            blank_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                tick_reg      <= tick_reg + CB'(1);
                last_edge_reg <= last_edge_next;
                period_reg    <= period_next;
                ref_reg[0]    <= ref_next[0];
                ref_reg[1]    <= ref_next[1];
                blank_reg     <= blank_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {period_ext[PW-1:0], blank_next};
        end
    end

`ifndef SYNTHESIS
    // the tick counter moves exactly once per processed tick
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> tick_reg == CB'($past(tick_reg) + CB'(1)))
        else $error("tick counter did not advance by one");

    a_tick_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(tick_reg) && $stable(period_reg))
        else $error("timer state changed without a processed tick");

    // result carries the state just written
    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_data_reg[NCH-1:0] == blank_reg
                    && out_data_reg[NCH+PW-1:NCH] == PW'(period_reg))
        else $error("result does not match timer state");

    // end of blanking reloads the reference with the latest edge time
    a_reload_a: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && blank_reg[0] && !blank_next[0] |=> ref_reg[0] == last_edge_reg)
        else $error("channel A reference not reloaded");

    a_reload_b: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && blank_reg[1] && !blank_next[1] |=> ref_reg[1] == last_edge_reg)
        else $error("channel B reference not reloaded");
`endif

endmodule
